@@ design/stfs_pkg.sv @@
// Shared constants, codes and the coil pattern table for the stepper sequencer.
package stfs_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned StepW    = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned CoilW    = 4;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned CalibW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CmdW-1:0] MODE_TICK   = 3'd0;
  localparam logic [CmdW-1:0] MODE_STEPS  = 3'd1;
  localparam logic [CmdW-1:0] MODE_LENGTH = 3'd2;
  localparam logic [CmdW-1:0] MODE_RUN    = 3'd3;
  localparam logic [CmdW-1:0] MODE_LOCK   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_STEP_DELAY  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CALIB_STEPS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CALIB_LEN   = 2'd2;

  localparam logic [DelayW-1:0] STEP_DELAY_RST  = 32'd2000;
  localparam logic [CalibW-1:0] CALIB_STEPS_RST = 16'd2048;
  localparam logic [CalibW-1:0] CALIB_LEN_RST   = 16'd10;

  localparam logic [CoilW-1:0]        COIL_OFF     = 4'd0;
  localparam logic signed [StepW-1:0] RELOAD_STEPS = 32'sd4;
  localparam logic [1:0]              PHASE_MAX    = 2'd3;

  localparam logic signed [StepW-1:0] STEP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [StepW-1:0] STEP_MIN = 32'sh8000_0000;

  function automatic logic [CoilW-1:0] coil_pattern(input logic [1:0] phase);
    logic [CoilW-1:0] pat;
    unique case (phase)
      2'd0: pat = 4'd10;
      2'd1: pat = 4'd6;
      2'd2: pat = 4'd5;
      2'd3: pat = 4'd9;
      default: pat = COIL_OFF;
    endcase
    return pat;
  endfunction

endpackage

@@ design/stepper_full_step_sequencer.sv @@
// Four-coil full-step stepper sequencer with step counting, length scaling and timing.
// One command word is taken at a time; the input is ready again once the result
// has been moved into the output register. Tick, run, lock and unused words pass
// from the execute state straight to the done state; a step word goes through the
// add state first. A length word takes a multiply step, then a restoring divider
// that settles one quotient bit per cycle, then a step to restore the sign and a
// saturating add. A length word with a zero calibration length goes straight to
// the done state. A finished result waits in the output register while the next
// word is already taken. Configuration writes are accepted in every cycle.
module stepper_full_step_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [stfs_pkg::CmdW-1:0]            mode_i,
  input  logic signed [stfs_pkg::StepW-1:0]    step_count_i,
  input  logic signed [stfs_pkg::LenW-1:0]     length_mm_i,
  input  logic                                 run_flag_i,
  input  logic                                 lock_flag_i,
  input  logic [stfs_pkg::TimeW-1:0]           time_us_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [stfs_pkg::CoilW-1:0]           coils_o,
  output logic                                 coils_written_o,
  output logic                                 moving_o,
  output logic signed [stfs_pkg::StepW-1:0]    pending_steps_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [stfs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [stfs_pkg::CfgDataW-1:0]        cfg_data_i
);
  import stfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_ADD, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [DelayW-1:0] delay_q, delay_d;
  logic [CalibW-1:0] csteps_q, csteps_d;
  logic [CalibW-1:0] clen_q, clen_d;

  logic signed [StepW-1:0] pend_q, pend_d;
  logic [TimeW-1:0]        last_q, last_d;
  logic                    cont_q, cont_d;
  logic                    lock_q, lock_d;

  logic [CmdW-1:0]         mode_q, mode_d;
  logic signed [StepW-1:0] step_q, step_d;
  logic signed [LenW-1:0]  len_q, len_d;
  logic                    flag_q, flag_d;
  logic [TimeW-1:0]        time_q, time_d;

  logic [CoilW-1:0]        rcoil_q, rcoil_d;
  logic                    rwr_q, rwr_d;

  logic signed [StepW:0]   add_q, add_d;
  logic [StepW-1:0]        mag_q, mag_d;
  logic [CalibW-1:0]       rem_q, rem_d;
  logic [4:0]              cnt_q, cnt_d;
  logic                    neg_q, neg_d;

  logic                    ovld_q, ovld_d;
  logic [CoilW-1:0]        ocoil_q, ocoil_d;
  logic                    owr_q, owr_d;
  logic signed [StepW-1:0] opend_q, opend_d;

  logic [TimeW-1:0]        elapsed;
  logic                    due;
  logic signed [StepW:0]   prod;
  logic [CalibW:0]         trial;
  logic signed [StepW+1:0] sum;

  assign elapsed = time_q - last_q;
  assign due     = !lock_q && (elapsed >= {{(TimeW-DelayW){1'b0}}, delay_q});
  assign prod    = len_q * $signed({1'b0, csteps_q});
  assign trial   = {rem_q, mag_q[StepW-1]} - {1'b0, clen_q};
  assign sum     = {{2{pend_q[StepW-1]}}, pend_q} + {add_q[StepW], add_q};

  always_comb begin
    state_d  = state_q;
    delay_d  = delay_q;
    csteps_d = csteps_q;
    clen_d   = clen_q;
    pend_d   = pend_q;
    last_d   = last_q;
    cont_d   = cont_q;
    lock_d   = lock_q;
    mode_d   = mode_q;
    step_d   = step_q;
    len_d    = len_q;
    flag_d   = flag_q;
    time_d   = time_q;
    rcoil_d  = rcoil_q;
    rwr_d    = rwr_q;
    add_d    = add_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    ovld_d   = ovld_q;
    ocoil_d  = ocoil_q;
    owr_d    = owr_q;
    opend_d  = opend_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_DELAY:  delay_d  = cfg_data_i;
        REG_CALIB_STEPS: csteps_d = cfg_data_i[CalibW-1:0];
        REG_CALIB_LEN:   clen_d   = cfg_data_i[CalibW-1:0];
        default: ;
      endcase
    end

    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          step_d  = step_count_i;
          len_d   = length_mm_i;
          flag_d  = (mode_i == MODE_LOCK) ? lock_flag_i : run_flag_i;
          time_d  = time_us_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rcoil_d = COIL_OFF;
        rwr_d   = 1'b0;
        state_d = S_DONE;
        unique case (mode_q)
          MODE_TICK: begin
            if (due) begin
              last_d = time_q;
              if (pend_q < 0) begin
                rcoil_d = coil_pattern(2'(~pend_q[1:0] + 2'd1));
                rwr_d   = 1'b1;
                pend_d  = pend_q + 32'sd1;
              end else if (pend_q > 0) begin
                rcoil_d = coil_pattern(PHASE_MAX - pend_q[1:0]);
                rwr_d   = 1'b1;
                pend_d  = pend_q - 32'sd1;
              end else if (cont_q) begin
                pend_d = RELOAD_STEPS;
              end else begin
                rwr_d = 1'b1;
              end
            end
          end
          MODE_STEPS: begin
            add_d   = {step_q[StepW-1], step_q};
            state_d = S_ADD;
          end
          MODE_LENGTH: begin
            if (clen_q != '0) begin
              state_d = S_MUL;
            end
          end
          MODE_RUN: begin
            rwr_d  = 1'b1;
            cont_d = flag_q;
            if (!flag_q) begin
              pend_d = '0;
            end
          end
          MODE_LOCK: begin
            lock_d = flag_q;
            if (flag_q) begin
              rwr_d  = 1'b1;
              cont_d = 1'b0;
              pend_d = '0;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        neg_d   = prod[StepW];
        mag_d   = prod[StepW] ? StepW'(-prod) : prod[StepW-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!trial[CalibW]) begin
          rem_d = trial[CalibW-1:0];
        end else begin
          rem_d = {rem_q[CalibW-2:0], mag_q[StepW-1]};
        end
        mag_d = {mag_q[StepW-2:0], !trial[CalibW]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (mode_q == MODE_LENGTH) begin
          add_d = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
          mode_d = MODE_STEPS;
        end else begin
          if (sum[StepW+1:StepW-1] == 3'b000 || sum[StepW+1:StepW-1] == 3'b111) begin
            pend_d = sum[StepW-1:0];
          end else begin
            pend_d = sum[StepW+1] ? STEP_MIN : STEP_MAX;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          ocoil_d = rcoil_q;
          owr_d   = rwr_q;
          opend_d = pend_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      delay_q  <= STEP_DELAY_RST;
      csteps_q <= CALIB_STEPS_RST;
      clen_q   <= CALIB_LEN_RST;
      pend_q   <= '0;
      last_q   <= '0;
      cont_q   <= 1'b0;
      lock_q   <= 1'b0;
      mode_q   <= MODE_TICK;
      step_q   <= '0;
      len_q    <= '0;
      flag_q   <= 1'b0;
      time_q   <= '0;
      rcoil_q  <= COIL_OFF;
      rwr_q    <= 1'b0;
      add_q    <= '0;
      mag_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      ovld_q   <= 1'b0;
      ocoil_q  <= COIL_OFF;
      owr_q    <= 1'b0;
      opend_q  <= '0;
    end else begin
      state_q  <= state_d;
      delay_q  <= delay_d;
      csteps_q <= csteps_d;
      clen_q   <= clen_d;
      pend_q   <= pend_d;
      last_q   <= last_d;
      cont_q   <= cont_d;
      lock_q   <= lock_d;
      mode_q   <= mode_d;
      step_q   <= step_d;
      len_q    <= len_d;
      flag_q   <= flag_d;
      time_q   <= time_d;
      rcoil_q  <= rcoil_d;
      rwr_q    <= rwr_d;
      add_q    <= add_d;
      mag_q    <= mag_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      neg_q    <= neg_d;
      ovld_q   <= ovld_d;
      ocoil_q  <= ocoil_d;
      owr_q    <= owr_d;
      opend_q  <= opend_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = ovld_q;
  assign coils_o         = ocoil_q;
  assign coils_written_o = owr_q;
  assign moving_o        = (opend_q != '0);
  assign pending_steps_o = opend_q;

`ifndef SYNTH
  a_coils_off_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !coils_written_o) |-> (coils_o == COIL_OFF))
    else $error("coils driven on a word that wrote no coils");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the done state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted word did not start execution");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != 5'd31) |=> (state_q == S_DIV))
    else $error("divider left early");

  a_locked_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && mode_q == MODE_TICK && lock_q) |=> $stable(pend_q))
    else $error("locked tick moved the count");
`endif

endmodule

@@ verif/stfs_checker.sv @@
// Checker for the stepper sequencer: predicts each result word and compares it on output.
`timescale 1ns / 100ps

module stfs_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [stfs_pkg::CmdW-1:0]         mode_i,
  input  logic signed [stfs_pkg::StepW-1:0] step_count_i,
  input  logic signed [stfs_pkg::LenW-1:0]  length_mm_i,
  input  logic                              run_flag_i,
  input  logic                              lock_flag_i,
  input  logic [stfs_pkg::TimeW-1:0]        time_us_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [stfs_pkg::CoilW-1:0]        coils_i,
  input  logic                              coils_written_i,
  input  logic                              moving_i,
  input  logic signed [stfs_pkg::StepW-1:0] pending_steps_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [stfs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [stfs_pkg::CfgDataW-1:0]     cfg_data_i,
  output int                                results_due_o,
  output int                                mismatches_o
);
  import stfs_pkg::*;

  typedef struct packed {
    logic [CoilW-1:0]        coils;
    logic                    written;
    logic                    moving;
    logic signed [StepW-1:0] pending;
  } coil_word_t;

  localparam logic [CoilW-1:0] PHASE_COILS [4] = '{4'd10, 4'd6, 4'd5, 4'd9};

  logic [DelayW-1:0]       step_delay_q;
  logic [CalibW-1:0]       calib_steps_q;
  logic [CalibW-1:0]       calib_len_q;
  logic signed [StepW-1:0] pending_q;
  logic [TimeW-1:0]        last_step_us;
  logic                    run_q;
  logic                    locked_q;
  coil_word_t              coil_words_due[$];

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches_o++;
  endtask

  function automatic logic signed [StepW-1:0] clamp_steps(input longint sum);
    if (sum > longint'(STEP_MAX)) return STEP_MAX;
    if (sum < longint'(STEP_MIN)) return STEP_MIN;
    return sum[StepW-1:0];
  endfunction

  function automatic coil_word_t advance_motor(input logic [CmdW-1:0] mode,
                                               input logic signed [StepW-1:0] steps,
                                               input logic signed [LenW-1:0] len_mm,
                                               input logic run, input logic lock,
                                               input logic [TimeW-1:0] now_us);
    coil_word_t w;
    logic [TimeW-1:0] gap;
    logic [StepW-1:0] mag;
    logic [1:0] ph;
    longint scaled;
    w = '0;
    gap = now_us - last_step_us;
    case (mode)
      MODE_TICK: begin
        if (!locked_q && gap >= {32'd0, step_delay_q}) begin
          last_step_us = now_us;
          if (pending_q < 0) begin
            mag = -pending_q;
            w.coils = PHASE_COILS[mag[1:0]];
            w.written = 1'b1;
            pending_q = pending_q + 1;
          end else if (pending_q > 0) begin
            ph = PHASE_MAX - pending_q[1:0];
            w.coils = PHASE_COILS[ph];
            w.written = 1'b1;
            pending_q = pending_q - 1;
          end else if (run_q) begin
            pending_q = RELOAD_STEPS;
          end else begin
            w.written = 1'b1;
          end
        end
      end
      MODE_STEPS: pending_q = clamp_steps(longint'(pending_q) + longint'(steps));
      MODE_LENGTH: begin
        if (calib_len_q != '0) begin
          scaled = longint'(len_mm) * longint'(calib_steps_q);
          pending_q = clamp_steps(longint'(pending_q) + scaled / longint'(calib_len_q));
        end
      end
      MODE_RUN: begin
        w.written = 1'b1;
        run_q = run;
        if (!run) pending_q = '0;
      end
      MODE_LOCK: begin
        locked_q = lock;
        if (lock) begin
          w.written = 1'b1;
          run_q = 1'b0;
          pending_q = '0;
        end
      end
      default: ;
    endcase
    w.moving = (pending_q != 0);
    w.pending = pending_q;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coil_word_t want;
    if (!rst_ni) begin
      step_delay_q = STEP_DELAY_RST;
      calib_steps_q = CALIB_STEPS_RST;
      calib_len_q = CALIB_LEN_RST;
      pending_q = '0;
      last_step_us = '0;
      run_q = 1'b0;
      locked_q = 1'b0;
      coil_words_due.delete();
      results_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STEP_DELAY:  step_delay_q = cfg_data_i;
          REG_CALIB_STEPS: calib_steps_q = cfg_data_i[CalibW-1:0];
          REG_CALIB_LEN:   calib_len_q = cfg_data_i[CalibW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (coil_words_due.size() == 0) begin
          report_mismatch("unexpected result word, pending_steps", pending_steps_i, 0);
        end else begin
          want = coil_words_due.pop_front();
          if (coils_i !== want.coils) report_mismatch("coils", coils_i, want.coils);
          if (coils_written_i !== want.written)
            report_mismatch("coils_written", coils_written_i, want.written);
          if (moving_i !== want.moving) report_mismatch("moving", moving_i, want.moving);
          if (pending_steps_i !== want.pending)
            report_mismatch("pending_steps", pending_steps_i, want.pending);
        end
      end
      if (in_valid_i && in_ready_i)
        coil_words_due.push_back(advance_motor(mode_i, step_count_i, length_mm_i,
                                               run_flag_i, lock_flag_i, time_us_i));
      results_due_o <= coil_words_due.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the stepper sequencer: clock, reset, command words, registers, verdict.
`timescale 1ns / 100ps

module testbench;
  import stfs_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 180;
  localparam int LONG_HOLD   = 300;
  localparam int END_WAIT    = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [CmdW-1:0]         mode;
    logic signed [StepW-1:0] steps;
    logic signed [LenW-1:0]  len;
    logic                    run;
    logic                    lock;
    logic [TimeW-1:0]        now;
  } motor_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [CmdW-1:0]         mode_i = MODE_TICK;
  logic signed [StepW-1:0] step_count_i = '0;
  logic signed [LenW-1:0]  length_mm_i = '0;
  logic                    run_flag_i = 1'b0;
  logic                    lock_flag_i = 1'b0;
  logic [TimeW-1:0]        time_us_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CoilW-1:0]        coils_o;
  logic                    coils_written_o;
  logic                    moving_o;
  logic signed [StepW-1:0] pending_steps_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;

  int              results_due;
  int              mismatches;
  int              cycle_cnt = 0;
  logic            quiet = 1'b0;
  logic            hold_req = 1'b0;
  bit              hold_done = 1'b0;
  logic [TimeW-1:0]  now_us = '0;
  logic [DelayW-1:0] cur_delay = STEP_DELAY_RST;

  always #6 clk_i = ~clk_i;

  stepper_full_step_sequencer u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .mode_i, .step_count_i, .length_mm_i, .run_flag_i, .lock_flag_i, .time_us_i,
    .out_valid_o, .out_ready_i,
    .coils_o, .coils_written_o, .moving_o, .pending_steps_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  stfs_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .mode_i, .step_count_i, .length_mm_i, .run_flag_i, .lock_flag_i, .time_us_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .coils_i(coils_o), .coils_written_i(coils_written_o), .moving_i(moving_o),
    .pending_steps_i(pending_steps_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .results_due_o(results_due), .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side backpressure
  always begin
    @(posedge clk_i);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_ready_i <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk_i);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(0, 16)) @(posedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic motor_word_t make_word(input logic [CmdW-1:0] mode,
                                            input logic signed [StepW-1:0] steps,
                                            input logic signed [LenW-1:0] len,
                                            input logic run, input logic lock,
                                            input logic [TimeW-1:0] now);
    motor_word_t w;
    w.mode = mode;
    w.steps = steps;
    w.len = len;
    w.run = run;
    w.lock = lock;
    w.now = now;
    return w;
  endfunction

  function automatic motor_word_t random_word();
    motor_word_t w;
    int unsigned pick;
    int unsigned roll;
    logic [TimeW-1:0] span;
    w = make_word(MODE_TICK, $urandom, 16'($urandom), 1'($urandom), 1'($urandom),
                  {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 19);
    if (pick < 55) begin
      if (roll == 0) now_us = {$urandom, $urandom};
      else if (roll == 1) now_us = now_us - 64'($urandom_range(0, 100));
      else begin
        span = {31'd0, cur_delay, 1'b0} + 64'd2;
        now_us = now_us + ({$urandom, $urandom} % span);
      end
      w.now = now_us;
    end else if (pick < 70) begin
      w.mode = MODE_STEPS;
      if (roll > 2) w.steps = 32'($urandom_range(0, 24)) - 32'd12;
    end else if (pick < 80) begin
      w.mode = MODE_LENGTH;
      if (roll > 3) w.len = 16'($urandom_range(0, 6)) - 16'd3;
    end else if (pick < 88) begin
      w.mode = MODE_RUN;
    end else if (pick < 96) begin
      w.mode = MODE_LOCK;
      w.lock = ($urandom_range(0, 9) < 4);
    end else begin
      w.mode = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  task automatic issue_word(input motor_word_t w);
    mode_i <= w.mode;
    step_count_i <= w.steps;
    length_mm_i <= w.len;
    run_flag_i <= w.run;
    lock_flag_i <= w.lock;
    time_us_i <= w.now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_phase_regs(input int p);
    logic [DelayW-1:0] dly;
    logic [CalibW-1:0] csteps;
    logic [CalibW-1:0] clen;
    case (p)
      0: begin dly = '0; csteps = 16'd1; clen = 16'd1; end
      1: begin dly = 32'hFFFF_FFFF; csteps = 16'hFFFF; clen = 16'hFFFF; end
      2: begin dly = 32'd3; csteps = CALIB_STEPS_RST; clen = CALIB_LEN_RST; end
      3: begin
        dly = $urandom_range(0, 40);
        csteps = 16'($urandom_range(1, 65535));
        clen = 16'($urandom_range(1, 65535));
      end
      4: begin dly = 32'd1; csteps = '0; clen = '0; end
      5: begin dly = 32'd7; csteps = 16'hFFFF; clen = 16'd1; end
      default: begin
        dly = $urandom_range(0, 20);
        csteps = 16'($urandom);
        clen = 16'($urandom_range(1, 300));
      end
    endcase
    write_reg(REG_STEP_DELAY, dly);
    write_reg(REG_CALIB_STEPS, {16'd0, csteps});
    write_reg(REG_CALIB_LEN, {16'd0, clen});
    if (p == 3) write_reg(REG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
    cur_delay = dly;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, hand-picked corners
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd2000));
    issue_word(make_word(MODE_STEPS, 32'sd5, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd4000));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd4500));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd6000));
    issue_word(make_word(MODE_STEPS, STEP_MIN, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_STEPS, STEP_MIN, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd8000));
    issue_word(make_word(MODE_STEPS, STEP_MAX, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_STEPS, STEP_MAX, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_STEPS, STEP_MAX, 0, 0, 0, 64'd0));
    issue_word(make_word(MODE_LENGTH, 0, -16'sd32768, 0, 0, 64'd0));
    issue_word(make_word(MODE_LENGTH, 0, 16'sd32767, 0, 0, 64'd0));
    issue_word(make_word(MODE_LENGTH, 0, -16'sd7, 0, 0, 64'd0));
    issue_word(make_word(MODE_RUN, 0, 0, 1'b1, 0, 64'd0));
    issue_word(make_word(MODE_RUN, 0, 0, 1'b0, 0, 64'd0));
    issue_word(make_word(MODE_RUN, 0, 0, 1'b1, 0, 64'd0));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'd2000));
    issue_word(make_word(MODE_LOCK, 0, 0, 0, 1'b1, 64'd0));
    issue_word(make_word(MODE_TICK, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
    issue_word(make_word(MODE_LOCK, 0, 0, 0, 1'b0, 64'd0));
    issue_word(make_word(3'd5, 32'sd1, 16'sd1, 1'b1, 1'b1, 64'd0));
    issue_word(make_word(3'd7, 32'sd1, 16'sd1, 1'b1, 1'b1, 64'd0));
    issue_word(make_word(MODE_LOCK, 0, 0, 0, 1'b0, 64'd0));
    now_us = 64'h8000_0000_0000_0000;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == PHASES - 1) quiet <= 1'b1;
      set_phase_regs(p);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 2 && i == 20) hold_req <= 1'b1;
        if (p == 3 && i == 90) drain_results();
        issue_word(random_word());
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
